// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the formatter RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, off while in reset.
`define UDF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define UDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/udf_pkg.sv =====
// Package for the unsigned decimal formatter: sizes, character codes, enums
// and the double-dabble step. No dependencies.
package udf_pkg;

  localparam int ArgWidth  = 64;
  localparam int MaxDigits = 20;
  localparam int BcdWidth  = MaxDigits * 4;
  localparam int BitCntW   = $clog2(ArgWidth + 1);
  localparam int DigCntW   = $clog2(MaxDigits + 1);

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChLower_l = 8'h6C;
  localparam logic [7:0] ChLower_u = 8'h75;
  localparam logic [7:0] ChZero    = 8'h30;

  localparam logic KindChar  = 1'b0;
  localparam logic KindError = 1'b1;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_PCT  = 2'd1,
    MODE_L    = 2'd2
  } udf_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CONV = 2'd1,
    ST_SKIP = 2'd2,
    ST_EMIT = 2'd3
  } udf_state_e;

  // One double-dabble step: add 3 to every digit >= 5, then shift in one bit.
  function automatic logic [BcdWidth-1:0] udf_dabble(input logic [BcdWidth-1:0] bcd,
                                                     input logic bit_in);
    logic [BcdWidth-1:0] adj;
    logic [3:0]          dig;
    adj = bcd;
    for (int i = 0; i < MaxDigits; i++) begin
      dig = bcd[i*4 +: 4];
      if (dig >= 4'd5) begin
        adj[i*4 +: 4] = dig + 4'd3;
      end
    end
    return {adj[BcdWidth-2:0], bit_in};
  endfunction

endpackage

// ===== hdl/udf_in_if.sv =====
// Input channel of the formatter: format byte, argument, end-of-format flag.
// Valid/ready handshake; no dependencies.
interface udf_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  fmt_char;
  logic [63:0] arg_value;
  logic        format_end;

  modport source (output valid, fmt_char, arg_value, format_end, input ready);
  modport sink   (input valid, fmt_char, arg_value, format_end, output ready);
endinterface

// ===== hdl/udf_out_if.sv =====
// Output channel of the formatter: emitted byte, kind and last flag.
// Valid/ready handshake; no dependencies.
interface udf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       kind;
  logic       last;

  modport source (output valid, out_char, kind, last, input ready);
  modport sink   (input valid, out_char, kind, last, output ready);
endinterface

// ===== hdl/unsigned_decimal_formatter.sv =====
// Unsigned decimal formatter top level. Uses udf_pkg, udf_in_if, udf_out_if
// and assert_macros.svh.
//
// Takes one format byte per item and streams out characters: plain text is
// echoed, "%%" gives "%", "%lu" prints the item's argument in unsigned
// decimal (no leading zeros, a zero value prints "0"), and a bad byte after
// "%" or "%l" gives one error result (kind = 1, out_char = 0) and is dropped.
// format_end = 1 returns the parser to text after that byte. The final result
// of each item carries last = 1. An item that gives one result or none waits
// only for the output register to free up. A "u" that completes "%lu" starts
// the bit-serial double-dabble conversion (one argument bit per cycle into a
// BCD shift register), then drops the leading zeros one digit at a time, finds
// the first digit and emits the digits. Zeros and digits always add up to
// MaxDigits. Input is held off while a conversion runs and its digits are
// emitted.
module unsigned_decimal_formatter (
  input logic    clk_i,
  input logic    rst_ni,
  udf_in_if.sink   in_i,
  udf_out_if.source out_o
);
  import udf_pkg::*;

  udf_state_e state_q, state_d;
  udf_mode_e  mode_q, mode_d;

  logic [ArgWidth-1:0] shift_q, shift_d;   // argument bits, MSB first
  logic [BcdWidth-1:0] bcd_q, bcd_d;       // decimal digits, most significant on top
  logic [BitCntW-1:0]  bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0]  dig_cnt_q, dig_cnt_d; // digits still in play

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_kind_q, out_kind_d;
  logic       out_last_q, out_last_d;

  logic       out_free;    // output register empty or being drained
  logic       in_fire;
  logic       emit_fire;
  logic [3:0] top_digit;

  assign top_digit = bcd_q[BcdWidth-1 -: 4];

  // ---------------- control strobes ----------------
  always_comb begin
    out_free  = !out_valid_q || out_o.ready;
    in_i.ready = (state_q == ST_IDLE) && out_free;
    in_fire   = in_i.valid && in_i.ready;
    emit_fire = (state_q == ST_EMIT) && out_free;
  end

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (mode_q == MODE_L) && (in_i.fmt_char == ChLower_u)) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bit_cnt_q == BitCntW'(1)) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // stop at the first nonzero digit, or at the units digit
        if (!((dig_cnt_q > DigCntW'(1)) && (top_digit == 4'd0))) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_fire && (dig_cnt_q == DigCntW'(1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------- parser and datapath ----------------
  always_comb begin
    mode_d      = mode_q;
    shift_d     = shift_q;
    bcd_d       = bcd_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;

    if (in_fire) begin
      case (mode_q)
        MODE_PCT: begin
          if (in_i.fmt_char == ChLower_l) begin
            mode_d = MODE_L;
          end else if (in_i.fmt_char == ChPercent) begin
            out_valid_d = 1'b1;
            out_char_d  = ChPercent;
            out_kind_d  = KindChar;
            out_last_d  = 1'b1;
            mode_d      = MODE_TEXT;
          end else begin
            out_valid_d = 1'b1;
            out_char_d  = 8'h00;
            out_kind_d  = KindError;
            out_last_d  = 1'b1;
          end
        end
        MODE_L: begin
          if (in_i.fmt_char == ChLower_u) begin
            shift_d   = in_i.arg_value[ArgWidth-1:0];
            bcd_d     = '0;
            bit_cnt_d = BitCntW'(ArgWidth);
            mode_d    = MODE_TEXT;
          end else begin
            out_valid_d = 1'b1;
            out_char_d  = 8'h00;
            out_kind_d  = KindError;
            out_last_d  = 1'b1;
          end
        end
        default: begin
          // text, and the unused mode code, which acts as text
          if (in_i.fmt_char == ChPercent) begin
            mode_d = MODE_PCT;
          end else begin
            out_valid_d = 1'b1;
            out_char_d  = in_i.fmt_char;
            out_kind_d  = KindChar;
            out_last_d  = 1'b1;
            mode_d      = MODE_TEXT;
          end
        end
      endcase
      if (in_i.format_end) begin
        mode_d = MODE_TEXT;
      end
    end

    case (state_q)
      ST_CONV: begin
        bcd_d     = udf_dabble(bcd_q, shift_q[ArgWidth-1]);
        shift_d   = {shift_q[ArgWidth-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - BitCntW'(1);
        dig_cnt_d = DigCntW'(MaxDigits);
      end
      ST_SKIP: begin
        if ((dig_cnt_q > DigCntW'(1)) && (top_digit == 4'd0)) begin
          bcd_d     = {bcd_q[BcdWidth-5:0], 4'd0};
          dig_cnt_d = dig_cnt_q - DigCntW'(1);
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          out_valid_d = 1'b1;
          out_char_d  = ChZero | {4'd0, top_digit};
          out_kind_d  = KindChar;
          out_last_d  = (dig_cnt_q == DigCntW'(1));
          bcd_d       = {bcd_q[BcdWidth-5:0], 4'd0};
          dig_cnt_d   = dig_cnt_q - DigCntW'(1);
        end
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_TEXT;
      out_valid_q <= 1'b0;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q    <= shift_d;
    bcd_q      <= bcd_d;
    out_char_q <= out_char_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_char = out_char_q;
  assign out_o.kind     = out_kind_q;
  assign out_o.last     = out_last_q;

  // ---------------- assertions ----------------
`include "assert_macros.svh"

  `UDF_ASSERT_IMP(a_err_char_zero, out_o.valid && (out_o.kind == KindError), out_o.out_char == 8'h00, "error result with nonzero char")
  `UDF_ASSERT_NEXT(a_conv_done, (state_q == ST_CONV) && (bit_cnt_q == BitCntW'(1)), state_q == ST_SKIP, "conversion did not end after the last bit")
  `UDF_ASSERT_NEXT(a_emit_loads, (state_q == ST_EMIT) && !out_valid_q, out_valid_q, "digit not loaded into free output register")
  `UDF_ASSERT_IMP(a_busy_no_ready, state_q != ST_IDLE, !in_i.ready, "input taken during conversion")

endmodule

// ===== test/unsigned_decimal_formatter_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for unsigned_decimal_formatter: %lu, %% and text stream.
// Depends on udf_pkg, udf_in_if, udf_out_if and the formatter RTL.
module unsigned_decimal_formatter_tb;
  import udf_pkg::*;

  // No-accept watchdog limit. It covers the long output hold-off, a full
  // 64-bit conversion and the worst sink stalls.
  localparam int StallLimit  = 2000;
  // Output hold-off length in the backpressure test.
  localparam int HoldCycles  = 300;
  // Quiet cycles after the last expected result. Covers a full conversion.
  localparam int TailCycles  = 150;

  typedef struct packed {
    logic [7:0] out_char;
    logic       kind;
    logic       last;
  } fmt_result_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic [63:0] arg;
  } fmt_byte_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  udf_in_if  in_if ();
  udf_out_if out_if ();

  unsigned_decimal_formatter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state and the results still owed by the block.
  udf_mode_e   parse_mode_q;
  fmt_result_t expected_out_q[$];

  // Knobs shared between the test tasks and the sink process.
  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  bit hold_req     = 1'b0;

  int fail_count   = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int conversions  = 0;
  int format_errs  = 0;

  // --------------------------------------------------------------------
  // Predictor: one format byte in, the results it must produce out.
  // --------------------------------------------------------------------
  function automatic void predict_format_byte(input logic [7:0] ch, input logic [63:0] arg,
                                              input logic fend);
    fmt_result_t res_q[$];
    logic [63:0] v;
    logic [3:0]  digs[MaxDigits];
    int          cnt;
    case (parse_mode_q)
      MODE_PCT: begin
        if (ch == ChLower_l) begin
          parse_mode_q = MODE_L;
        end else if (ch == ChPercent) begin
          res_q.push_back('{ChPercent, KindChar, 1'b0});
          parse_mode_q = MODE_TEXT;
        end else begin
          // bad byte after a percent: dropped, mode kept
          res_q.push_back('{8'h00, KindError, 1'b0});
          format_errs++;
        end
      end
      MODE_L: begin
        if (ch == ChLower_u) begin
          // argument masked to ArgWidth; shift by 64 gives zero, so the mask wraps to all ones
          v   = arg & ((64'd1 << ArgWidth) - 64'd1);
          cnt = 0;
          while (v != 0 && cnt < MaxDigits) begin
            digs[cnt] = 4'(v % 64'd10);
            v         = v / 64'd10;
            cnt++;
          end
          // keep only the low MaxDigits digits, then drop leading zeros
          while (cnt > 1 && digs[cnt-1] == 4'd0) cnt--;
          if (cnt == 0) begin
            digs[0] = 4'd0;
            cnt     = 1;
          end
          for (int i = cnt - 1; i >= 0; i--) begin
            res_q.push_back('{ChZero + 8'(digs[i]), KindChar, 1'b0});
          end
          parse_mode_q = MODE_TEXT;
          conversions++;
        end else begin
          res_q.push_back('{8'h00, KindError, 1'b0});
          format_errs++;
        end
      end
      default: begin
        // text mode; an unused mode code would behave the same way
        if (ch == ChPercent) begin
          parse_mode_q = MODE_PCT;
        end else begin
          res_q.push_back('{ch, KindChar, 1'b0});
          parse_mode_q = MODE_TEXT;
        end
      end
    endcase
    if (fend) parse_mode_q = MODE_TEXT;
    if (res_q.size() > 0) res_q[res_q.size()-1].last = 1'b1;
    foreach (res_q[i]) expected_out_q.push_back(res_q[i]);
  endfunction

  // Argument with a spread of magnitudes so every digit count shows up.
  function automatic logic [63:0] random_arg();
    logic [63:0] a;
    a = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: a = '0;
      1: a = '1;
      2: begin
        a = 64'd1;
        repeat ($urandom_range(0, 19)) a = a * 64'd10;
      end
      3: a = a % 64'd1000;
      4, 5: a = a >> $urandom_range(1, 63);
      default: ;
    endcase
    return a;
  endfunction

  // --------------------------------------------------------------------
  // Sender. Called right after a rising edge; returns at the edge where
  // the item was taken. valid stays high so back-to-back items need no
  // second assignment in the same step.
  // --------------------------------------------------------------------
  task automatic send_item(input logic [7:0] ch, input logic [63:0] arg, input logic fend);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.fmt_char   <= ch;
    in_if.arg_value  <= arg;
    in_if.format_end <= fend;
    // ready is sampled mid-cycle, where nothing is changing
    @(negedge clk_i);
    while (!in_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    predict_format_byte(ch, arg, fend);
    items_sent++;
  endtask

  // Sender pause: drop valid and wait until every owed result has come.
  // At least one edge passes, so the next item starts in a new step.
  task automatic wait_all_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_out_q.size() != 0) @(posedge clk_i);
  endtask

  // One random format: mostly well-formed pieces, some broken ones, some
  // raw noise, and now and then a format cut off after % or %l.
  task automatic send_random_format();
    fmt_byte_t  bytes_q[$];
    logic [7:0] b;
    logic       fend;
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: begin
          do b = 8'($urandom_range(0, 255)); while (b == ChPercent);
          bytes_q.push_back('{b, {$urandom, $urandom}});
        end
        7, 8, 9: begin
          bytes_q.push_back('{ChPercent, {$urandom, $urandom}});
          bytes_q.push_back('{ChPercent, {$urandom, $urandom}});
        end
        10, 11, 12, 13, 14, 15: begin
          bytes_q.push_back('{ChPercent, {$urandom, $urandom}});
          bytes_q.push_back('{ChLower_l, {$urandom, $urandom}});
          bytes_q.push_back('{ChLower_u, random_arg()});
        end
        16, 17: begin
          do b = 8'($urandom_range(0, 255)); while (b == ChPercent || b == ChLower_l);
          bytes_q.push_back('{ChPercent, {$urandom, $urandom}});
          bytes_q.push_back('{b, {$urandom, $urandom}});
        end
        18: begin
          do b = 8'($urandom_range(0, 255)); while (b == ChLower_u);
          bytes_q.push_back('{ChPercent, {$urandom, $urandom}});
          bytes_q.push_back('{ChLower_l, {$urandom, $urandom}});
          bytes_q.push_back('{b, {$urandom, $urandom}});
        end
        default: begin
          bytes_q.push_back('{8'($urandom_range(0, 255)), {$urandom, $urandom}});
        end
      endcase
    end
    if ($urandom_range(0, 7) == 0) begin
      bytes_q.push_back('{ChPercent, {$urandom, $urandom}});
      if ($urandom_range(0, 1)) bytes_q.push_back('{ChLower_l, {$urandom, $urandom}});
    end
    foreach (bytes_q[i]) begin
      // an occasional early end marker too
      fend = (i == bytes_q.size() - 1) || ($urandom_range(0, 39) == 0);
      send_item(bytes_q[i].ch, bytes_q[i].arg, fend);
    end
  endtask

  // --------------------------------------------------------------------
  // Test tasks
  // --------------------------------------------------------------------
  task automatic test_text_echo();
    send_item(8'h41, '0, 1'b0);
    send_item(8'h00, '1, 1'b0);
    send_item(8'hFF, '0, 1'b0);
    send_item(ChLower_l, '1, 1'b0);
    send_item(ChLower_u, '1, 1'b1);
    wait_all_results();
  endtask

  task automatic test_percent_escape();
    send_item(ChPercent, '0, 1'b0);
    send_item(ChPercent, '1, 1'b1);
    wait_all_results();
  endtask

  task automatic test_decimal_extremes();
    // zero, largest value, and a 20-digit value that is mostly zeros
    send_item(ChPercent, '0, 1'b0);
    send_item(ChLower_l, '0, 1'b0);
    send_item(ChLower_u, 64'd0, 1'b0);
    send_item(ChPercent, '0, 1'b0);
    send_item(ChLower_l, '0, 1'b0);
    send_item(ChLower_u, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_item(ChPercent, '0, 1'b0);
    send_item(ChLower_l, '0, 1'b0);
    send_item(ChLower_u, 64'd10000000000000000000, 1'b1);
    wait_all_results();
  endtask

  task automatic test_bad_sequences();
    // error after %, mode stays so the next % closes the escape
    send_item(ChPercent, '0, 1'b0);
    send_item(8'h78, '0, 1'b0);
    send_item(ChPercent, '0, 1'b0);
    // error after %l, mode stays so the next u converts
    send_item(ChPercent, '0, 1'b0);
    send_item(ChLower_l, '0, 1'b0);
    send_item(ChPercent, '0, 1'b0);
    send_item(ChLower_u, 64'd1, 1'b1);
    wait_all_results();
  endtask

  task automatic test_format_end_midway();
    // pending % and %l are dropped silently when the format ends
    send_item(ChPercent, '0, 1'b1);
    send_item(ChLower_l, '0, 1'b0);
    send_item(ChPercent, '0, 1'b0);
    send_item(ChLower_l, '0, 1'b1);
    send_item(ChLower_u, '1, 1'b1);
    wait_all_results();
  endtask

  task automatic test_random_formats(input int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_random_format();
    wait_all_results();
  endtask

  // Sink holds off for a long stretch while the sender keeps offering.
  task automatic test_output_backpressure();
    int stop_at;
    stop_at  = items_sent + 40;
    hold_req = 1'b1;
    while (items_sent < stop_at) send_random_format();
    wait_all_results();
  endtask

  // --------------------------------------------------------------------
  // Sink: random stall bursts, or one long hold-off on request.
  // --------------------------------------------------------------------
  initial begin : sink_ready_drive
    out_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // --------------------------------------------------------------------
  // Result checker. Sampled mid-cycle: a handshake seen here completes
  // at the next rising edge.
  // --------------------------------------------------------------------
  always @(negedge clk_i) begin : result_check
    fmt_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_out_q.size() == 0) begin
        $error("unexpected result: out_char=%h kind=%b last=%b",
               out_if.out_char, out_if.kind, out_if.last);
        fail_count++;
      end else begin
        want = expected_out_q.pop_front();
        if (out_if.out_char !== want.out_char) begin
          $error("out_char mismatch: expected %h, actual %h", want.out_char, out_if.out_char);
          fail_count++;
        end
        if (out_if.kind !== want.kind) begin
          $error("kind mismatch: expected %b, actual %b", want.kind, out_if.kind);
          fail_count++;
        end
        if (out_if.last !== want.last) begin
          $error("last mismatch: expected %b, actual %b", want.last, out_if.last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too many cycles in a row with no handshake on either side.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(negedge clk_i);
      if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $error("timeout: %0d cycles without a handshake", StallLimit);
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------
  initial begin : main_seq
    in_if.valid      = 1'b0;
    in_if.fmt_char   = '0;
    in_if.arg_value  = '0;
    in_if.format_end = 1'b0;
    parse_mode_q     = MODE_TEXT;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_text_echo();
    test_percent_escape();
    test_decimal_extremes();
    test_bad_sequences();
    test_format_end_midway();
    test_random_formats(200);
    test_output_backpressure();
    test_random_formats(150);
    // last stretch runs flat out on both sides
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_random_formats(100);

    wait_all_results();
    repeat (TailCycles) @(posedge clk_i);
    if (expected_out_q.size() != 0) begin
      $error("%0d results never arrived", expected_out_q.size());
      fail_count++;
    end

    $display("Covered %0d format bytes and %0d output characters, with %0d decimal conversions",
             items_sent, results_seen, conversions);
    $display("and %0d bad-format errors, an output hold-off and an idle-free tail.", format_errs);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/udf_pkg.sv
hdl/udf_in_if.sv
hdl/udf_out_if.sv
hdl/unsigned_decimal_formatter.sv
test/unsigned_decimal_formatter_tb.sv
